[sv/aesrt_pkg.sv]
`timescale 1ns / 1ps
package aesrt_pkg;

	typedef enum logic [2:0] {
		OP_ADD_KEY   = 3'd0,
		OP_SUB       = 3'd1,
		OP_INV_SUB   = 3'd2,
		OP_SHIFT     = 3'd3,
		OP_INV_SHIFT = 3'd4,
		OP_MIX       = 3'd5,
		OP_INV_MIX   = 3'd6,
		OP_PASS      = 3'd7
	} op_t;

	typedef logic [7:0] byte_t;
	typedef byte_t [15:0] blk_t;

	localparam byte_t RED_POLY = 8'h1b;

	function automatic byte_t xtime(input byte_t a);
		xtime = a[7] ? ((a << 1) ^ RED_POLY) : (a << 1);
	endfunction

	function automatic byte_t gf_mul(input byte_t a, input byte_t b);
		byte_t acc;
		byte_t x;
		acc = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc = acc ^ x;
			x = xtime(x);
		end
		gf_mul = acc;
	endfunction

	function automatic byte_t gf_inv(input byte_t x);
		byte_t r;
		byte_t base;
		logic [7:0] e;
		r = 8'h01;
		base = x;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i]) r = gf_mul(r, base);
			base = gf_mul(base, base);
		end
		gf_inv = r;
	endfunction

	function automatic byte_t rotl(input byte_t v, input int n);
		rotl = byte_t'((v << n) | (v >> (8 - n)));
	endfunction

	function automatic byte_t sbox_f(input byte_t x);
		byte_t b;
		b = gf_inv(x);
		sbox_f = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
	endfunction

	function automatic byte_t rsbox_f(input byte_t s);
		rsbox_f = gf_inv(rotl(s, 1) ^ rotl(s, 3) ^ rotl(s, 6) ^ 8'h05);
	endfunction

	typedef byte_t [255:0] tab_t;

	function automatic tab_t mk_sbox();
		tab_t t;
		for (int i = 0; i < 256; i++) t[i] = sbox_f(byte_t'(i));
		mk_sbox = t;
	endfunction

	function automatic tab_t mk_rsbox();
		tab_t t;
		for (int i = 0; i < 256; i++) t[i] = rsbox_f(byte_t'(i));
		mk_rsbox = t;
	endfunction

	localparam tab_t SBOX  = mk_sbox();
	localparam tab_t RSBOX = mk_rsbox();

	function automatic blk_t unpack_blk(input logic [63:0] hi, input logic [63:0] lo);
		blk_t b;
		for (int n = 0; n < 8; n++) begin
			b[n]     = hi[56 - 8*n +: 8];
			b[n + 8] = lo[56 - 8*n +: 8];
		end
		unpack_blk = b;
	endfunction

endpackage

[sv/aesrt_stage_a.sv]
`timescale 1ns / 1ps
module aesrt_stage_a
	import aesrt_pkg::*;
(
	input  op_t  op,
	input  blk_t s,
	input  blk_t k,
	output blk_t t
);
	always_comb begin
		t = s;
		case (op)
			OP_ADD_KEY: for (int c = 0; c < 16; c++) t[c] = s[c] ^ k[c];
			OP_SUB:     for (int c = 0; c < 16; c++) t[c] = SBOX[s[c]];
			OP_INV_SUB: for (int c = 0; c < 16; c++) t[c] = RSBOX[s[c]];
			OP_SHIFT:
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++) t[4*c + r] = s[4*((c + r) % 4) + r];
			OP_INV_SHIFT:
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++) t[4*((c + r) % 4) + r] = s[4*c + r];
			default: t = s;
		endcase
	end
endmodule

[sv/aesrt_mix.sv]
`timescale 1ns / 1ps
module aesrt_mix
	import aesrt_pkg::*;
(
	input  op_t  op,
	input  blk_t s,
	output blk_t t
);
	always_comb begin
		t = s;
		for (int c = 0; c < 4; c++) begin
			if (op == OP_MIX) begin
				t[4*c+0] = xtime(s[4*c]) ^ gf_mul(s[4*c+1], 8'h03) ^ s[4*c+2] ^ s[4*c+3];
				t[4*c+1] = s[4*c] ^ xtime(s[4*c+1]) ^ gf_mul(s[4*c+2], 8'h03) ^ s[4*c+3];
				t[4*c+2] = s[4*c] ^ s[4*c+1] ^ xtime(s[4*c+2]) ^ gf_mul(s[4*c+3], 8'h03);
				t[4*c+3] = gf_mul(s[4*c], 8'h03) ^ s[4*c+1] ^ s[4*c+2] ^ xtime(s[4*c+3]);
			end else if (op == OP_INV_MIX) begin
				for (int r = 0; r < 4; r++)
					t[4*c+r] = gf_mul(s[4*c + r], 8'h0e)
						^ gf_mul(s[4*c + (r+1)%4], 8'h0b)
						^ gf_mul(s[4*c + (r+2)%4], 8'h0d)
						^ gf_mul(s[4*c + (r+3)%4], 8'h09);
			end
		end
	end
endmodule

[sv/aes_round_transforms_core.sv]
`timescale 1ns / 1ps
// Three-stage pipeline: one beat per cycle unless a low out_ready stalls the output; each
// beat passes the input register, byte/shift stage and column-mix stage to output register.
// Key is used only by add-key; code seven passes the state through.
module aes_round_transforms_core
	import aesrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [63:0] state_hi,
	input  logic [63:0] state_lo,
	input  logic [63:0] key_hi,
	input  logic [63:0] key_lo,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);
	logic v_s1, v_s2, v_s3;
	op_t  op_s1, op_s2;
	blk_t s_s1, k_s1, d_s2, d_s3, a_t, m_t;
	logic en3, en2, en1;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	aesrt_stage_a u_a (.op(op_s1), .s(s_s1), .k(k_s1), .t(a_t));
	aesrt_mix     u_m (.op(op_s2), .s(d_s2), .t(m_t));

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= op_t'(operation);
			s_s1  <= unpack_blk(state_hi, state_lo);
			k_s1  <= unpack_blk(key_hi, key_lo);
		end
		if (en2) begin
			op_s2 <= op_s1;
			d_s2  <= a_t;
		end
		if (en3) d_s3 <= m_t;
	end

	always_comb begin
		for (int n = 0; n < 8; n++) begin
			result_hi[56 - 8*n +: 8] = d_s3[n];
			result_lo[56 - 8*n +: 8] = d_s3[n + 8];
		end
	end
	assign out_valid = v_s3;
endmodule

[sv/aesrt_checker.sv]
`timescale 1ns / 1ps
module aesrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_hi,
	input logic [63:0] result_lo
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_hi) && $stable(result_lo))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("beat lost in pipeline");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("stall with empty output");
endmodule

bind aes_round_transforms_core aesrt_checker u_chk (.*);
